[design/spq_pkg.sv]
// Package for the sorted priority queue.
// Holds the status codes, the default capacity and the cell command struct.
// No dependencies.
package spq_pkg;

  localparam int unsigned SPQ_CAPACITY = 16;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned COUNT_W      = 5;
  localparam int unsigned STATUS_W     = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic                      insert;
    logic                      remove;
    logic signed [VALUE_W-1:0] value;
  } cell_cmd_t;

endpackage

[design/sorted_priority_queue_top.sv]
// Sorted priority queue, minimum first: top level.
// Result strobe comes in the cycle after start; one transaction per cycle.
// busy stays low; the receiver cannot stall and results are never held.
// Synchronous active-low reset empties the queue; cell values need no reset.
// Depends on spq_pkg and spq_cell.
module sorted_priority_queue_top #(
  parameter int unsigned CAPACITY = spq_pkg::SPQ_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_action,
  input  logic signed [spq_pkg::VALUE_W-1:0]  in_value,
  output logic                                out_valid,
  output logic signed [spq_pkg::VALUE_W-1:0]  out_value,
  output logic [spq_pkg::STATUS_W-1:0]        out_status,
  output logic [spq_pkg::COUNT_W-1:0]         out_count
);
  import spq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]            count_r, count_nxt;
  logic                        out_valid_r;
  logic signed [VALUE_W-1:0]   out_value_r, out_value_nxt;
  status_t                     out_status_r, out_status_nxt;
  logic [CNT_W+COUNT_W-1:0]    count_ext;

  logic                        accept;
  logic                        is_full, is_empty;
  cell_cmd_t                   cmd;

  logic [CAPACITY-1:0]         keep;
  logic signed [VALUE_W-1:0]   cell_value [CAPACITY];

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);

  assign cmd.insert = accept && !in_action && !is_full;
  assign cmd.remove = accept && in_action && !is_empty;
  assign cmd.value  = in_value;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic                      l_keep;
      logic signed [VALUE_W-1:0] l_value;
      logic signed [VALUE_W-1:0] r_value;
      if (i == 0) begin : g_first
        assign l_keep  = 1'b1;
        assign l_value = cell_value[i];
      end else begin : g_mid
        assign l_keep  = keep[i-1];
        assign l_value = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign r_value = cell_value[i];
      end else begin : g_inner
        assign r_value = cell_value[i+1];
      end
      spq_cell u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .occupied    (CNT_W'(i) < count_r),
        .left_keep   (l_keep),
        .left_value  (l_value),
        .right_value (r_value),
        .keep        (keep[i]),
        .value       (cell_value[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt      = count_r;
    out_value_nxt  = '0;
    out_status_nxt = ST_OK;
    priority if (cmd.insert) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.remove) begin
      count_nxt     = count_r - 1'b1;
      out_value_nxt = cell_value[0];
    end else if (accept && in_action) begin
      out_status_nxt = ST_EMPTY;
    end else if (accept) begin
      out_status_nxt = ST_FULL;
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_value_r  <= out_value_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign count_ext  = {{COUNT_W{1'b0}}, count_r};
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_count  = count_ext[COUNT_W-1:0];

endmodule

[design/spq_cell.sv]
// One storage cell of the sorted priority queue chain.
// Keeps its own value or takes the new value or a neighbor's value.
// Depends on spq_pkg.
module spq_cell (
  input  logic                               clk,
  input  spq_pkg::cell_cmd_t                 cmd,
  input  logic                               occupied,
  input  logic                               left_keep,
  input  logic signed [spq_pkg::VALUE_W-1:0] left_value,
  input  logic signed [spq_pkg::VALUE_W-1:0] right_value,
  output logic                               keep,
  output logic signed [spq_pkg::VALUE_W-1:0] value
);
  import spq_pkg::*;

  logic signed [VALUE_W-1:0] value_r;
  logic signed [VALUE_W-1:0] value_nxt;

  assign keep  = occupied && (value_r <= cmd.value);
  assign value = value_r;

  always_comb begin
    value_nxt = value_r;
    priority if (cmd.insert) begin
      if (!keep) begin
        value_nxt = left_keep ? cmd.value : left_value;
      end
    end else if (cmd.remove) begin
      value_nxt = right_value;
    end else begin
      value_nxt = value_r;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule
